FILE: rtl/core/gf2m_pkg.sv
// Shared types and command codes for the GF(2^m) arithmetic unit.
package gf2m_pkg;

	typedef enum logic [1:0] {
		CMD_ADD = 2'd0,
		CMD_MUL = 2'd1,
		CMD_DIV = 2'd2,
		CMD_POW = 2'd3
	} cmd_t;

	localparam int unsigned MOD_RESET_VAL = 283;

endpackage

FILE: rtl/core/gf2m_arith_unit.sv
// Top level of the GF(2^m) polynomial arithmetic unit: sequencer and shared shift-reduce step.
//
// Binary polynomial arithmetic (bit i = coefficient of x^i) reduced modulo the
// modulus register. A transaction starts at an edge where start is high and busy
// is low. The result appears on value/remainder/div_by_zero for exactly one
// cycle with done high, and must be captured then: there is no back-pressure.
// busy stays high for the whole transaction, and only one transaction is in
// flight at a time. All work runs through one shift/conditional-XOR step that
// handles one operand bit per cycle, so latency is set by how many bit passes a
// command needs (W = POLY_WIDTH):
//   every command starts with a degree search of modulus (or divisor)
//   add:    search, then one pass (reduce a^b)
//   mul:    search, then two passes (reduce a, then multiply)
//   div:    search, then one pass; zero divisor ends right after the search
//   power:  search, one pass (reduce a), then per exponent bit up to the highest
//           set one: a select step and a squaring pass, plus another select
//           step and a multiply pass if the bit is set, then a final select step
// Divide ignores the modulus and returns the plain quotient and remainder;
// a zero divisor gives value 0, remainder = operand_a and div_by_zero = 1.
// A zero modulus means no reduction: results are truncated to W bits.
// The modulus register is written through modulus_we/modulus_wdata and must
// only change while busy is low.
module gf2m_arith_unit
	import gf2m_pkg::*;
#(
	parameter int POLY_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  modulus_we,
	input  logic [POLY_WIDTH:0]   modulus_wdata,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            cmd,
	input  logic [POLY_WIDTH-1:0] operand_a,
	input  logic [POLY_WIDTH-1:0] operand_b,
	output logic                  done,
	output logic [POLY_WIDTH-1:0] value,
	output logic [POLY_WIDTH-1:0] remainder,
	output logic                  div_by_zero
);

	localparam int W     = POLY_WIDTH;
	localparam int CNT_W = $clog2(W);
	localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(W - 1);
	localparam logic [W:0]       TOP_INIT  = {1'b1, {W{1'b0}}};
	localparam logic [W:0]       MOD_RESET = (W + 1)'(MOD_RESET_VAL);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,     // find leading term of modulus or divisor
		ST_MUL,      // one bit of a shift-and-add multiply per cycle
		ST_DIV,      // one bit of long division per cycle
		ST_POW_SEL   // pick next square-and-multiply pass
	} state_t;

	// What a finished multiply pass feeds into.
	typedef enum logic [2:0] {
		JOB_ADD,
		JOB_RED_A,
		JOB_MUL_B,
		JOB_POW_ACC,
		JOB_POW_SQR
	} job_t;

	state_t         state_q;
	job_t           job_q;
	cmd_t           cmd_q;
	logic [W:0]     modulus_q;
	logic [W:0]     top_q;      // one-hot leading term, zero if word is zero
	logic [W-1:0]   a_q, b_q;
	logic [W-1:0]   r_q;        // running product / partial remainder
	logic [W-1:0]   x_q;        // multiplicand added on set bits
	logic [W-1:0]   y_q;        // bits fed MSB first
	logic [W-1:0]   q_q;        // quotient
	logic [W-1:0]   acc_q, base_q, exp_q;
	logic [CNT_W-1:0] cnt_q;
	logic           done_q, dz_q;
	logic [W-1:0]   value_q, remainder_q;

	logic [W:0]     scan_word;
	logic           scan_done;
	logic [W-1:0]   one_red;
	logic [W:0]     poly_sel;
	logic [W:0]     sh;
	logic [W:0]     red;
	logic [W-1:0]   add_x;
	logic           hit;
	logic [W-1:0]   nr;
	logic           cnt_last;

	// Leading-term search, one bit position per cycle.
	assign scan_word = (cmd_q == CMD_DIV) ? {1'b0, b_q} : modulus_q;
	assign scan_done = (|(scan_word & top_q)) || (top_q == '0);

	// The constant 1 reduced: zero when the modulus is 1 (leading term x^0).
	assign one_red = {{(W-1){1'b0}}, ~top_q[0]};

	// Shared step: shift in one bit, cancel the leading term, add multiplicand.
	always_comb begin
		poly_sel = (state_q == ST_DIV) ? {1'b0, b_q} : modulus_q;
		sh       = {r_q, (state_q == ST_DIV) ? y_q[W-1] : 1'b0};
		hit      = |(sh & top_q);
		red      = hit ? (sh ^ poly_sel) : sh;
		add_x    = ((state_q == ST_MUL) && y_q[W-1]) ? x_q : '0;
		nr       = red[W-1:0] ^ add_x;
	end

	assign cnt_last = (cnt_q == CNT_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			job_q       <= JOB_ADD;
			cmd_q       <= CMD_ADD;
			done_q      <= 1'b0;
			dz_q        <= 1'b0;
			modulus_q   <= MOD_RESET;
			top_q       <= '0;
			a_q         <= '0;
			b_q         <= '0;
			r_q         <= '0;
			x_q         <= '0;
			y_q         <= '0;
			q_q         <= '0;
			acc_q       <= '0;
			base_q      <= '0;
			exp_q       <= '0;
			cnt_q       <= '0;
			value_q     <= '0;
			remainder_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (modulus_we) begin
				modulus_q <= modulus_wdata;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						cmd_q   <= cmd_t'(cmd);
						a_q     <= operand_a;
						b_q     <= operand_b;
						top_q   <= TOP_INIT;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						cnt_q <= '0;
						r_q   <= '0;
						case (cmd_q)
							CMD_DIV: begin
								if (b_q == '0) begin
									value_q     <= '0;
									remainder_q <= a_q;
									dz_q        <= 1'b1;
									done_q      <= 1'b1;
									state_q     <= ST_IDLE;
								end else begin
									y_q     <= a_q;
									q_q     <= '0;
									state_q <= ST_DIV;
								end
							end
							CMD_ADD: begin
								x_q     <= one_red;
								y_q     <= a_q ^ b_q;
								job_q   <= JOB_ADD;
								state_q <= ST_MUL;
							end
							default: begin
								// reduce operand a first (1 * a)
								x_q     <= one_red;
								y_q     <= a_q;
								job_q   <= JOB_RED_A;
								state_q <= ST_MUL;
							end
						endcase
					end else begin
						top_q <= top_q >> 1;
					end
				end
				ST_MUL: begin
					r_q   <= nr;
					y_q   <= y_q << 1;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_last) begin
						r_q   <= '0;
						cnt_q <= '0;
						case (job_q)
							JOB_RED_A: begin
								if (cmd_q == CMD_MUL) begin
									x_q   <= nr;
									y_q   <= b_q;
									job_q <= JOB_MUL_B;
								end else begin
									base_q  <= nr;
									acc_q   <= one_red;
									exp_q   <= b_q;
									state_q <= ST_POW_SEL;
								end
							end
							JOB_POW_ACC: begin
								acc_q    <= nr;
								exp_q[0] <= 1'b0;
								state_q  <= ST_POW_SEL;
							end
							JOB_POW_SQR: begin
								base_q  <= nr;
								exp_q   <= exp_q >> 1;
								state_q <= ST_POW_SEL;
							end
							default: begin
								value_q     <= nr;
								remainder_q <= '0;
								dz_q        <= 1'b0;
								done_q      <= 1'b1;
								state_q     <= ST_IDLE;
							end
						endcase
					end
				end
				ST_POW_SEL: begin
					if (exp_q == '0) begin
						value_q     <= acc_q;
						remainder_q <= '0;
						dz_q        <= 1'b0;
						done_q      <= 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						cnt_q   <= '0;
						r_q     <= '0;
						x_q     <= base_q;
						state_q <= ST_MUL;
						if (exp_q[0]) begin
							y_q   <= acc_q;
							job_q <= JOB_POW_ACC;
						end else begin
							y_q   <= base_q;
							job_q <= JOB_POW_SQR;
						end
					end
				end
				ST_DIV: begin
					r_q   <= nr;
					y_q   <= y_q << 1;
					q_q   <= {q_q[W-2:0], hit};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_last) begin
						value_q     <= {q_q[W-2:0], hit};
						remainder_q <= nr;
						dz_q        <= 1'b0;
						done_q      <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign value       = value_q;
	assign remainder   = remainder_q;
	assign div_by_zero = dz_q;

	// Results only show up once the sequencer is back in idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done raised while sequencer busy");

	// An accepted transaction always makes the unit busy.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not start sequencer");

	// Leading-term marker never has more than one bit set.
	a_top_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> $onehot0(top_q))
		else $error("leading-term marker not one-hot");

	// Only divide produces a remainder or a zero-divisor flag.
	a_rem_div_only: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (cmd_q != CMD_DIV)) |-> ((remainder == '0) && !div_by_zero))
		else $error("remainder or flag set on non-divide transaction");

	// Zero divisor returns a zero quotient.
	a_dz_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && div_by_zero) |-> (value == '0))
		else $error("nonzero quotient on zero divisor");

endmodule
